>>> rtl/tcld_pkg.sv
// ----------------------------------------------------------------------------
// Track cache directory package
// Shared widths, default sizes, function codes and the structs that travel
// along the row of directory cells.
// ----------------------------------------------------------------------------
package tcld_pkg;

  localparam int DEF_ENTRIES      = 64;
  localparam int DEF_SECTOR_BYTES = 137;
  localparam int DEF_TRACK_BYTES  = 4384;

  localparam int FUNC_W     = 3;
  localparam int DRIVE_W    = 4;
  localparam int TRACK_W    = 8;
  localparam int SECTOR_W   = 5;
  localparam int SLOT_W     = 6;
  localparam int ADDR_W     = 19;
  localparam int COUNT_W    = 32;
  localparam int AGE_W      = 32;
  localparam int SLOT_IDX_W = 8;

  typedef enum logic [FUNC_W-1:0] {
    FN_READ  = 3'd0,
    FN_PROBE = 3'd1,
    FN_WRITE = 3'd2,
    FN_FILL  = 3'd3,
    FN_CLEAR = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  valid;
    logic [DRIVE_W-1:0]    drive;
    logic [TRACK_W-1:0]    track;
    logic                  hit_found;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  inv_found;
    logic [SLOT_IDX_W-1:0] inv_idx;
    logic [AGE_W-1:0]      best_age;
    logic [SLOT_IDX_W-1:0] best_idx;
  } scan_t;

  typedef struct packed {
    logic                  wr_en;
    logic                  tag_en;
    logic [SLOT_IDX_W-1:0] idx;
    logic [DRIVE_W-1:0]    drive;
    logic [TRACK_W-1:0]    track;
    logic [AGE_W-1:0]      age;
    logic                  clear;
  } upd_t;

endpackage

>>> rtl/tcld_cell.sv
// ----------------------------------------------------------------------------
// Track cache directory cell
// Holds one directory entry, folds it into the search beat passing by and
// hands the beat on, registered, to the next cell.
// ----------------------------------------------------------------------------
module tcld_cell import tcld_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  scan_t scan_in,
  input  upd_t  upd,
  output scan_t scan_out
);

  localparam logic [SLOT_IDX_W-1:0] MY_IDX = SLOT_IDX_W'(IDX);

  logic               valid;
  logic [DRIVE_W-1:0] drive;
  logic [TRACK_W-1:0] track;
  logic [AGE_W-1:0]   age;
  logic               hit_here;
  scan_t              scan_next;

  always_comb begin
    hit_here  = valid && (drive == scan_in.drive) && (track == scan_in.track);
    scan_next = scan_in;
    if (!scan_in.hit_found && hit_here) begin
      scan_next.hit_found = 1'b1;
      scan_next.hit_idx   = MY_IDX;
    end
    if (!scan_in.inv_found && !valid) begin
      scan_next.inv_found = 1'b1;
      scan_next.inv_idx   = MY_IDX;
    end
    if (age < scan_in.best_age) begin
      scan_next.best_age = age;
      scan_next.best_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out.valid <= 1'b0;
    end else begin
      scan_out.valid <= scan_in.valid;
    end
    if (scan_in.valid) begin
      scan_out.drive     <= scan_next.drive;
      scan_out.track     <= scan_next.track;
      scan_out.hit_found <= scan_next.hit_found;
      scan_out.hit_idx   <= scan_next.hit_idx;
      scan_out.inv_found <= scan_next.inv_found;
      scan_out.inv_idx   <= scan_next.inv_idx;
      scan_out.best_age  <= scan_next.best_age;
      scan_out.best_idx  <= scan_next.best_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (upd.clear) begin
      valid <= 1'b0;
    end else if (upd.wr_en && upd.tag_en && (upd.idx == MY_IDX)) begin
      valid <= 1'b1;
    end
    if (upd.wr_en && (upd.idx == MY_IDX)) begin
      age <= upd.age;
      if (upd.tag_en) begin
        drive <= upd.drive;
        track <= upd.track;
      end
    end
  end

endmodule

>>> rtl/track_cache_lru_directory.sv
// ----------------------------------------------------------------------------
// Track cache LRU directory
// Fully associative tag directory of a track cache with LRU replacement,
// built as a row of entry cells that a search beat walks through.
// ----------------------------------------------------------------------------
// Usage: a request beat (func, drive, track, sector) is taken on the input
// channel when in_valid and in_ready are both high. One result beat (hit,
// slot, data_address, evicted, hit_count, miss_count) follows for every
// request on the output channel, handed over when out_valid and out_ready
// are both high.
// The request is registered, and a registered go flag sends the search beat
// into the first cell; the beat moves one cell per cycle through the row
// and is captured at its end. The result is registered when the done state
// finishes, and the next request can be taken once the block is back in idle.
// The search time grows with the length of the cell row.
// The block works on one request at a time; in_ready is high only when no
// request is in progress. A result that waits for out_ready does not block
// the next request from being taken and searched, but that request's
// directory update waits until the output register is free.
// Reset invalidates every entry and clears the age counter and the hit and
// miss counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module track_cache_lru_directory import tcld_pkg::*; #(
  parameter int ENTRIES      = DEF_ENTRIES,
  parameter int SECTOR_BYTES = DEF_SECTOR_BYTES,
  parameter int TRACK_BYTES  = DEF_TRACK_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [FUNC_W-1:0]   func,
  input  logic [DRIVE_W-1:0]  drive,
  input  logic [TRACK_W-1:0]  track,
  input  logic [SECTOR_W-1:0] sector,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                hit,
  output logic [SLOT_W-1:0]   slot,
  output logic [ADDR_W-1:0]   data_address,
  output logic                evicted,
  output logic [COUNT_W-1:0]  hit_count,
  output logic [COUNT_W-1:0]  miss_count
);

  state_t               state;
  state_t               state_next;
  logic                 go;
  logic [FUNC_W-1:0]    req_func;
  logic [DRIVE_W-1:0]   req_drive;
  logic [TRACK_W-1:0]   req_track;
  logic [ADDR_W-1:0]    sector_off;
  scan_t                res;
  scan_t                head;
  scan_t                chain [ENTRIES];
  logic [ENTRIES-1:0]   chain_valid;
  upd_t                 upd;
  logic [AGE_W-1:0]     age_counter;
  logic [AGE_W-1:0]     age_counter_next;
  logic [COUNT_W-1:0]   hits;
  logic [COUNT_W-1:0]   hits_next;
  logic [COUNT_W-1:0]   misses;
  logic [COUNT_W-1:0]   misses_next;
  logic                 finish;
  logic                 r_hit;
  logic                 r_have_slot;
  logic                 r_evicted;
  logic [SLOT_IDX_W-1:0] r_slot;
  logic [31:0]          addr_sum;
  logic                 in_fire;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    head           = '0;
    head.valid     = go;
    head.drive     = req_drive;
    head.track     = req_track;
    head.best_age  = '1;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == 0) begin : g_first
      tcld_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .scan_in  (head),
        .upd      (upd),
        .scan_out (chain[i])
      );
    end else begin : g_next
      tcld_cell #(.IDX(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .scan_in  (chain[i-1]),
        .upd      (upd),
        .scan_out (chain[i])
      );
    end
    assign chain_valid[i] = chain[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      go    <= 1'b0;
    end else begin
      state <= state_next;
      go    <= in_fire;
    end
    if (in_fire) begin
      req_func   <= func;
      req_drive  <= drive;
      req_track  <= track;
      sector_off <= ADDR_W'(32'(sector) * 32'(SECTOR_BYTES));
    end
    if (chain[ENTRIES-1].valid) begin
      res <= chain[ENTRIES-1];
    end
  end

  always_comb begin
    state_next       = state;
    finish           = 1'b0;
    upd              = '0;
    upd.drive        = req_drive;
    upd.track        = req_track;
    age_counter_next = age_counter;
    hits_next        = hits;
    misses_next      = misses;
    r_hit            = 1'b0;
    r_have_slot      = 1'b0;
    r_evicted        = 1'b0;
    r_slot           = '0;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain[ENTRIES-1].valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          finish     = 1'b1;
          state_next = ST_IDLE;
          case (func_t'(req_func))
            FN_READ, FN_PROBE, FN_WRITE: begin
              if (res.hit_found) begin
                r_hit       = 1'b1;
                r_have_slot = 1'b1;
                r_slot      = res.hit_idx;
                if (func_t'(req_func) == FN_WRITE) begin
                  age_counter_next = age_counter + AGE_W'(2);
                end else begin
                  age_counter_next = age_counter + AGE_W'(1);
                end
                upd.wr_en = 1'b1;
                upd.idx   = res.hit_idx;
                upd.age   = age_counter_next;
                if (func_t'(req_func) == FN_READ) begin
                  hits_next = hits + COUNT_W'(1);
                end
              end else if (func_t'(req_func) == FN_READ) begin
                misses_next = misses + COUNT_W'(1);
              end
            end
            FN_FILL: begin
              r_have_slot = 1'b1;
              if (res.hit_found) begin
                r_hit            = 1'b1;
                r_slot           = res.hit_idx;
                age_counter_next = age_counter + AGE_W'(2);
              end else begin
                r_slot           = res.inv_found ? res.inv_idx : res.best_idx;
                r_evicted        = !res.inv_found;
                age_counter_next = age_counter + AGE_W'(1);
              end
              upd.wr_en  = 1'b1;
              upd.tag_en = 1'b1;
              upd.idx    = r_slot;
              upd.age    = age_counter_next;
            end
            FN_CLEAR: begin
              upd.clear        = 1'b1;
              age_counter_next = '0;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign addr_sum = 32'(r_slot) * 32'(TRACK_BYTES) + 32'(sector_off);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      age_counter <= '0;
      hits        <= '0;
      misses      <= '0;
    end else begin
      age_counter <= age_counter_next;
      hits        <= hits_next;
      misses      <= misses_next;
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (finish) begin
      hit          <= r_hit;
      slot         <= r_have_slot ? SLOT_W'(r_slot) : '0;
      data_address <= r_have_slot ? addr_sum[ADDR_W-1:0] : '0;
      evicted      <= r_evicted;
      hit_count    <= hits_next;
      miss_count   <= misses_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_one_beat_in_row: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("More than one search beat in the cell row.");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain[ENTRIES-1].valid |-> state == ST_SCAN)
    else $error("Search beat left the row outside the scan state.");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid && state == ST_IDLE)
    else $error("Finished request did not produce a result beat.");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted |-> !hit)
    else $error("Eviction reported together with a hit.");
`endif

endmodule
